// ===== hdl/assert_macros.svh =====
// Shared assertion macros for the arbiter checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("implication check failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/cdra_pkg.sv =====
package cdra_pkg;

    // Operation codes of an input beat
    localparam logic [1:0] KIND_ENQ  = 2'd0;
    localparam logic [1:0] KIND_DISP = 2'd1;
    localparam logic [1:0] KIND_CMPL = 2'd2;
    localparam logic [1:0] KIND_NOP  = 2'd3;

    // Class codes
    localparam logic [1:0] CLS_UX  = 2'd0;
    localparam logic [1:0] CLS_FG  = 2'd1;
    localparam logic [1:0] CLS_BG  = 2'd2;
    localparam logic [1:0] CLS_BAD = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_DISABLED  = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_FEATURE_ENABLE     = 3'd0;
    localparam logic [2:0] CFG_QUEUE_TAGGED       = 3'd1;
    localparam logic [2:0] CFG_TOTAL_DEPTH        = 3'd2;
    localparam logic [2:0] CFG_BACKGROUND_LIMIT   = 3'd3;
    localparam logic [2:0] CFG_RESERVE_BACKGROUND = 3'd4;
    localparam logic [2:0] CFG_RESERVE_FOREGROUND = 3'd5;
    localparam logic [2:0] CFG_RESERVE_URGENT     = 3'd6;
    localparam logic [2:0] CFG_ENABLE_THRESHOLD   = 3'd7;

    localparam int NUM_CLASSES = 3;
    localparam int CNT_BITS    = 8;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] req_class;
        logic [7:0] req_id;
        logic       at_front;
    } t_req;

    typedef struct packed {
        logic       granted;
        logic [1:0] grant_class;
        logic [7:0] grant_id;
        logic [1:0] status;
    } t_res;

    typedef struct packed {
        logic       feature_enable;
        logic       queue_tagged;
        logic [7:0] total_depth;
        logic [7:0] background_limit;
        logic [7:0] reserve_background;
        logic [7:0] reserve_foreground;
        logic [7:0] reserve_urgent;
        logic [7:0] enable_threshold;
    } t_cfg;

    // Queue command from the top level
    typedef struct packed {
        logic push;
        logic front;
        logic pop;
    } t_q_cmd;

    // Queue occupancy flags
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // Dispatch decision
    typedef struct packed {
        logic       grant;
        logic [1:0] cls;
    } t_pick;

endpackage

// ===== hdl/cdra_req_if.sv =====
interface cdra_req_if;
    logic          valid;
    logic          ready;
    cdra_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/cdra_res_if.sv =====
interface cdra_res_if;
    logic          valid;
    logic          ready;
    cdra_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/class_depth_reserving_io_arbiter.sv =====
// Channel   Dir  Payload                                   Handshake
// i_req     in   kind, req_class, req_id, at_front         valid/ready
// o_res     out  granted, grant_class, grant_id, status    valid/ready
// i_cfg_*   in   8 registers, index i_cfg_idx              write enable only
//
// One beat a cycle sustained while the result side is ready; each beat passes
// through the input register and then leaves through the result register.
// The queue head entries sit in registers, which lets dispatch read them combinationally.
// Reset is synchronous and clears pointers, counts, in-flight counters and flags.
// A stalled result holds in the output register while one more beat is taken.
module class_depth_reserving_io_arbiter #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdra_req_if.sink   i_req,
    cdra_res_if.source o_res,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    localparam int NC = cdra_pkg::NUM_CLASSES;
    localparam int CB = cdra_pkg::CNT_BITS;

    cdra_pkg::t_cfg   r_cfg;
    logic             r_in_valid;
    cdra_pkg::t_req   r_in;
    logic             r_out_valid;
    cdra_pkg::t_res   r_out, n_out;
    logic [CB-1:0]    r_inflight [NC];
    logic [CB-1:0]    n_inflight [NC];

    cdra_pkg::t_q_cmd  q_cmd  [NC];
    cdra_pkg::t_q_stat q_stat [NC];
    logic [ID_BITS-1:0] head_id [NC];
    logic [NC-1:0]      q_empty;
    cdra_pkg::t_pick    pick;

    logic               move;
    logic [1:0]         cls;
    logic [ID_BITS+7:0] id_wide;
    logic [ID_BITS-1:0] id_store;
    logic [ID_BITS+7:0] gid_wide;
    logic               do_push, do_pop;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.feature_enable     <= 1'b1;
            r_cfg.queue_tagged       <= 1'b1;
            r_cfg.total_depth        <= 8'd32;
            r_cfg.background_limit   <= 8'd8;
            r_cfg.reserve_background <= 8'd2;
            r_cfg.reserve_foreground <= 8'd2;
            r_cfg.reserve_urgent     <= 8'd2;
            r_cfg.enable_threshold   <= 8'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cdra_pkg::CFG_FEATURE_ENABLE:     r_cfg.feature_enable     <= i_cfg_data[0];
                cdra_pkg::CFG_QUEUE_TAGGED:       r_cfg.queue_tagged       <= i_cfg_data[0];
                cdra_pkg::CFG_TOTAL_DEPTH:        r_cfg.total_depth        <= i_cfg_data;
                cdra_pkg::CFG_BACKGROUND_LIMIT:   r_cfg.background_limit   <= i_cfg_data;
                cdra_pkg::CFG_RESERVE_BACKGROUND: r_cfg.reserve_background <= i_cfg_data;
                cdra_pkg::CFG_RESERVE_FOREGROUND: r_cfg.reserve_foreground <= i_cfg_data;
                cdra_pkg::CFG_RESERVE_URGENT:     r_cfg.reserve_urgent     <= i_cfg_data;
                cdra_pkg::CFG_ENABLE_THRESHOLD:   r_cfg.enable_threshold   <= i_cfg_data;
                default:                          r_cfg                    <= r_cfg;
            endcase
        end
    end

    // Beat moves from input register to result register
    assign move        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) r_in <= i_req.data;
    end

    // Decode the stored id and the class
    assign cls      = (r_in.req_class == cdra_pkg::CLS_BAD) ? cdra_pkg::CLS_BG : r_in.req_class;
    assign id_wide  = {{ID_BITS{1'b0}}, r_in.req_id};
    assign id_store = id_wide[ID_BITS-1:0];

    assign do_push = move && (r_in.kind == cdra_pkg::KIND_ENQ) && r_cfg.feature_enable
                     && !q_stat[cls].full;
    assign do_pop  = move && (r_in.kind == cdra_pkg::KIND_DISP) && pick.grant;

    // Per-class queues
    for (genvar c = 0; c < NC; c++) begin : g_q
        assign q_cmd[c].push  = do_push && (cls == 2'(c));
        assign q_cmd[c].front = r_in.at_front;
        assign q_cmd[c].pop   = do_pop && (pick.cls == 2'(c));
        assign q_empty[c]     = q_stat[c].empty;

        cdra_queue #(
            .DEPTH   (QUEUE_DEPTH),
            .ID_BITS (ID_BITS)
        ) u_queue (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (q_cmd[c]),
            .i_id      (id_store),
            .o_stat    (q_stat[c]),
            .o_head_id (head_id[c])
        );
    end

    cdra_pick u_pick (
        .i_cfg      (r_cfg),
        .i_inflight (r_inflight),
        .i_empty    (q_empty),
        .o_pick     (pick)
    );

    assign gid_wide = {8'd0, head_id[pick.cls]};

    // Build the result and the next in-flight counts
    always_comb begin
        n_out      = '0;
        n_inflight = r_inflight;
        unique case (r_in.kind)
            cdra_pkg::KIND_ENQ: begin
                if (!r_cfg.feature_enable) n_out.status = cdra_pkg::ST_DISABLED;
                else if (q_stat[cls].full) n_out.status = cdra_pkg::ST_FULL;
                else                       n_out.status = cdra_pkg::ST_OK;
            end
            cdra_pkg::KIND_DISP: begin
                if (pick.grant) begin
                    n_out.granted     = 1'b1;
                    n_out.grant_class = pick.cls;
                    n_out.grant_id    = gid_wide[7:0];
                    if (r_inflight[pick.cls] != {CB{1'b1}}) begin
                        n_inflight[pick.cls] = r_inflight[pick.cls] + CB'(1);
                    end
                end
            end
            cdra_pkg::KIND_CMPL: begin
                if (r_inflight[cls] == '0) n_out.status = cdra_pkg::ST_UNDERFLOW;
                else n_inflight[cls] = r_inflight[cls] - CB'(1);
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int c = 0; c < NC; c++) r_inflight[c] <= '0;
        end else begin
            if (move) begin
                r_out_valid <= 1'b1;
                r_inflight  <= n_inflight;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) r_out <= n_out;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

// ===== hdl/cdra_queue.sv =====
module cdra_queue #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cdra_pkg::t_q_cmd     i_cmd,
    input  logic [ID_BITS-1:0]   i_id,
    output cdra_pkg::t_q_stat    o_stat,
    output logic [ID_BITS-1:0]   o_head_id
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);

    logic [ID_BITS-1:0] mem [DEPTH];
    logic [PTR_W-1:0]   r_head_ptr, n_head_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ID_BITS-1:0] r_head_id;

    logic [PTR_W-1:0] head_prev, head_next, tail_ptr, wr_ptr;
    logic [SUM_W-1:0] tail_sum, tail_wrap;
    logic             empty;

    assign empty     = (r_count == '0);
    assign head_prev = (r_head_ptr == '0) ? LAST_PTR : r_head_ptr - PTR_W'(1);
    assign head_next = (r_head_ptr == LAST_PTR) ? '0 : r_head_ptr + PTR_W'(1);

    // Tail slot is head plus count, wrapped once
    assign tail_sum  = SUM_W'(r_head_ptr) + SUM_W'(r_count);
    assign tail_wrap = (tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum;
    assign tail_ptr  = tail_wrap[PTR_W-1:0];
    assign wr_ptr    = i_cmd.front ? head_prev : tail_ptr;

    // Advance pointers and occupancy
    always_comb begin
        n_head_ptr = r_head_ptr;
        n_count    = r_count;
        if (i_cmd.push) begin
            if (i_cmd.front) n_head_ptr = head_prev;
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_head_ptr = head_next;
            n_count    = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_ptr <= '0;
            r_count    <= '0;
        end else begin
            r_head_ptr <= n_head_ptr;
            r_count    <= n_count;
        end
    end

    // Store entries and keep the head entry in a register
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) mem[wr_ptr] <= i_id;
        if (i_cmd.push && (i_cmd.front || empty)) begin
            r_head_id <= i_id;
        end else if (i_cmd.pop) begin
            r_head_id <= mem[head_next];
        end
    end

    assign o_stat.empty = empty;
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_head_id    = r_head_id;

endmodule

// ===== hdl/cdra_pick.sv =====
module cdra_pick (
    input  cdra_pkg::t_cfg                   i_cfg,
    input  logic [cdra_pkg::CNT_BITS-1:0]    i_inflight [cdra_pkg::NUM_CLASSES],
    input  logic [cdra_pkg::NUM_CLASSES-1:0] i_empty,
    output cdra_pkg::t_pick                  o_pick
);

    logic signed [10:0] td, uxfg_lim, ux_lim, fg_lim, iu, ifg, ib, bgl, sum_uf;
    logic               active, ux_e, fg_e, bg_e, uf_open;

    assign active = i_cfg.queue_tagged && (i_cfg.background_limit != '0)
                    && (i_cfg.total_depth >= i_cfg.enable_threshold);

    // Signed class limits
    assign td       = signed'({3'b000, i_cfg.total_depth});
    assign uxfg_lim = td - signed'({3'b000, i_cfg.reserve_background});
    assign ux_lim   = uxfg_lim - signed'({3'b000, i_cfg.reserve_foreground});
    assign fg_lim   = uxfg_lim - signed'({3'b000, i_cfg.reserve_urgent});
    assign iu       = signed'({3'b000, i_inflight[0]});
    assign ifg      = signed'({3'b000, i_inflight[1]});
    assign ib       = signed'({3'b000, i_inflight[2]});
    assign bgl      = signed'({3'b000, i_cfg.background_limit});
    assign sum_uf   = iu + ifg;

    assign ux_e    = i_empty[0];
    assign fg_e    = i_empty[1];
    assign bg_e    = i_empty[2];
    assign uf_open = (sum_uf < uxfg_lim) || bg_e;

    // When active, pick urgent, then foreground, then background
    always_comb begin
        o_pick.grant = 1'b0;
        o_pick.cls   = cdra_pkg::CLS_UX;
        if (active) begin
            priority if (uf_open && !ux_e && ((iu < ux_lim) || fg_e)) begin
                o_pick.grant = 1'b1;
                o_pick.cls   = cdra_pkg::CLS_UX;
            end else if (uf_open && !fg_e && ((ifg < fg_lim) || ux_e)) begin
                o_pick.grant = 1'b1;
                o_pick.cls   = cdra_pkg::CLS_FG;
            end else if (!bg_e && (ib < bgl)) begin
                o_pick.grant = 1'b1;
                o_pick.cls   = cdra_pkg::CLS_BG;
            end else begin
                o_pick.grant = 1'b0;
            end
        end
    end

endmodule

// ===== hdl/cdra_checker.sv =====
`include "assert_macros.svh"

module cdra_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           i_ready,
    input cdra_pkg::t_res i_data
);

    // A beat without a grant carries no class and no id
    `ASSERT_IMPLY(a_nogrant_zero, i_clk, i_rst_n, i_valid && !i_data.granted, (i_data.grant_class == cdra_pkg::CLS_UX) && (i_data.grant_id == 8'd0))

    // A grant always reports ok status
    `ASSERT_IMPLY(a_grant_ok, i_clk, i_rst_n, i_valid && i_data.granted, i_data.status == cdra_pkg::ST_OK)

    // A grant never names the unused class code
    `ASSERT_IMPLY(a_grant_class, i_clk, i_rst_n, i_valid && i_data.granted, i_data.grant_class != cdra_pkg::CLS_BAD)

    // Hold a stalled result beat
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_data))

endmodule

bind class_depth_reserving_io_arbiter cdra_checker u_cdra_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_data  (o_res.data)
);
